FILE: rtl/pgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pgs_pkg
// Shared types and constants for the Gauss-Seidel Poisson solver.
// ---------------------------------------------------------------------------
package pgs_pkg;
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_BITS  = $clog2(CELLS);
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_SOLVE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TOL    = 2'd2;
  localparam logic [1:0] REG_SWEEPS = 2'd3;

  localparam logic [62:0] CAP63    = {63{1'b1}};
  localparam logic [33:0] SQ_LIMIT = 34'd3037000499;

  typedef struct packed {
    logic [1:0]         kind;
    logic [11:0]        cell_index;
    logic signed [31:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [15:0]        sweep_count;
    logic               converged;
    logic [62:0]        residual_squared;
  } out_item_t;

  // datapath operation selected by the controller
  typedef enum logic [2:0] {
    OP_NONE, OP_CLEAR, OP_UPDATE, OP_RESID, OP_LOAD, OP_READ
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [ADDR_BITS-1:0] addr;
    logic [COL_BITS-1:0]  col;
    logic [ROW_BITS-1:0]  row;
    logic                 acc_clear;
    logic signed [31:0]   value;
  } dp_cmd_t;
endpackage
`default_nettype wire

FILE: rtl/pgs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pgs_datapath
// Cell stores, stencil update and residual accumulation.
// A read port per neighbor is avoided by reading the five taps in turn
// through one read port; the controller steps through them.
// ---------------------------------------------------------------------------
module pgs_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pgs_pkg::dp_cmd_t              cmd,
  input  wire logic [2:0]                    tap,
  input  wire logic [pgs_pkg::COL_BITS:0]    width,
  input  wire logic [pgs_pkg::ROW_BITS:0]    height,
  output logic signed [31:0]                 read_data,
  output logic [62:0]                        acc
);
  logic signed [31:0] rhs_mem [pgs_pkg::CELLS];
  logic signed [31:0] sol_mem [pgs_pkg::CELLS];
  logic signed [31:0] sol_q, rhs_q;
  logic [pgs_pkg::ADDR_BITS-1:0] raddr, addr_d;
  logic valid_tap, valid_d;
  logic [2:0] tap_d;
  logic signed [34:0] sum;
  logic signed [31:0] self_v, rhs_v;
  logic signed [36:0] diff;
  logic [35:0] mag;
  logic [62:0] sq;
  logic [62:0] sq_sat;
  logic [63:0] acc_sum;
  logic signed [34:0] upd;
  logic signed [31:0] upd_sat;
  logic wr_en, sq_valid;

  // tap 0 west, 1 east, 2 north, 3 south, 4 center/rhs
  always_comb begin
    raddr = cmd.addr;
    valid_tap = 1'b1;
    case (tap)
      3'd0: begin
        raddr = cmd.addr - 1'b1;
        valid_tap = cmd.col != '0;
      end
      3'd1: begin
        raddr = cmd.addr + 1'b1;
        valid_tap = ({1'b0, cmd.col} + 1'b1) < width;
      end
      3'd2: begin
        raddr = cmd.addr - pgs_pkg::ADDR_BITS'(width);
        valid_tap = cmd.row != '0;
      end
      3'd3: begin
        raddr = cmd.addr + pgs_pkg::ADDR_BITS'(width);
        valid_tap = ({1'b0, cmd.row} + 1'b1) < height;
      end
      default: raddr = cmd.addr;
    endcase
  end

  // west tap of the next cell reads the cell being written: forward it
  always_ff @(posedge clk) begin
    sol_q <= (wr_en && addr_d == raddr) ? upd_sat : sol_mem[raddr];
    rhs_q <= rhs_mem[cmd.addr];
    if (cmd.op == pgs_pkg::OP_LOAD) rhs_mem[cmd.addr] <= cmd.value;
    if (cmd.op == pgs_pkg::OP_CLEAR) sol_mem[cmd.addr] <= '0;
    else if (wr_en) sol_mem[addr_d] <= upd_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_d <= '0;
      valid_d <= 1'b0;
    end else begin
      tap_d <= (cmd.op == pgs_pkg::OP_UPDATE || cmd.op == pgs_pkg::OP_RESID) ? tap : 3'd7;
      valid_d <= valid_tap;
    end
    addr_d <= cmd.addr;
  end

  assign read_data = sol_q;
  assign upd = (sum - 35'(rhs_q)) >>> 2;
  assign upd_sat = (upd > 35'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                   (upd < -35'sh80000000) ? -32'sh80000000 : upd[31:0];

  logic is_upd;
  always_ff @(posedge clk) begin
    if (rst) is_upd <= 1'b0;
    else if (cmd.op == pgs_pkg::OP_UPDATE) is_upd <= 1'b1;
    else if (cmd.op == pgs_pkg::OP_RESID) is_upd <= 1'b0;
  end
  assign wr_en = (tap_d == 3'd4) && is_upd;

  always_ff @(posedge clk) begin
    if (tap_d == 3'd0) sum <= valid_d ? 35'(sol_q) : '0;
    else if (tap_d < 3'd4 && valid_d) sum <= sum + 35'(sol_q);
    if (tap_d == 3'd4) begin
      self_v <= sol_q;
      rhs_v <= rhs_q;
    end
  end

  // residual pipeline: diff, magnitude, square, accumulate
  logic sq_stage;
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_stage <= 1'b0;
      sq_valid <= 1'b0;
    end else begin
      sq_stage <= (tap_d == 3'd4) && !is_upd;
      sq_valid <= sq_stage;
    end
    diff <= 37'(rhs_v) - (37'(sum) - (37'(self_v) <<< 2));
    mag <= diff[36] ? 36'(-diff) : 36'(diff);
  end

  logic sq_v2, sq_v3;
  assign sq = mag[31:0] * mag[31:0];
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v2 <= 1'b0;
      sq_v3 <= 1'b0;
    end else begin
      sq_v2 <= sq_valid;
      sq_v3 <= sq_v2;
    end
    sq_sat <= (mag > 36'(pgs_pkg::SQ_LIMIT)) ? pgs_pkg::CAP63 : sq;
  end

  assign acc_sum = {1'b0, acc} + {1'b0, sq_sat};
  always_ff @(posedge clk) begin
    if (rst || cmd.acc_clear) acc <= '0;
    else if (sq_v3) acc <= acc_sum[63] ? pgs_pkg::CAP63 : acc_sum[62:0];
  end
endmodule
`default_nettype wire

FILE: rtl/pgs_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pgs_controller
// Sequencer for load, read and solve transactions.
// ---------------------------------------------------------------------------
module pgs_controller (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire pgs_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output pgs_pkg::out_item_t              out_data,
  input  wire logic [pgs_pkg::COL_BITS:0] width,
  input  wire logic [pgs_pkg::ROW_BITS:0] height,
  input  wire logic [62:0]                tol,
  input  wire logic [15:0]                limit,
  output pgs_pkg::dp_cmd_t                cmd,
  output logic [2:0]                      tap,
  input  wire logic signed [31:0]         read_data,
  input  wire logic [62:0]                acc
);
  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_READ, S_CLEAR, S_UPD, S_RES, S_DRAIN, S_CHECK
  } state_t;
  state_t state;
  logic [pgs_pkg::ADDR_BITS-1:0] addr;
  logic [pgs_pkg::COL_BITS-1:0] col;
  logic [pgs_pkg::ROW_BITS-1:0] row;
  logic [3:0] drain;
  logic [15:0] sweeps;
  logic last_cell;
  logic in_acc;
  logic finish;
  logic out_set;

  assign in_stall = state != S_IDLE || (out_valid && out_stall);
  assign in_acc = in_valid && !in_stall;
  assign last_cell = ({1'b0, col} + 1'b1 == width) && ({1'b0, row} + 1'b1 == height);
  assign finish = acc < tol || sweeps >= limit;
  assign out_set = (state == S_IDLE && in_acc &&
                    !(in_data.kind inside {pgs_pkg::KIND_READ, pgs_pkg::KIND_SOLVE})) ||
                   state == S_READ || (state == S_CHECK && finish);

  always_comb begin
    cmd = '0;
    cmd.addr = addr;
    cmd.col = col;
    cmd.row = row;
    cmd.op = pgs_pkg::OP_NONE;
    if (state == S_IDLE && in_acc) begin
      cmd.addr = in_data.cell_index;
      cmd.value = in_data.cell_value;
      if (in_data.kind == pgs_pkg::KIND_LOAD) cmd.op = pgs_pkg::OP_LOAD;
      if (in_data.kind == pgs_pkg::KIND_READ) cmd.op = pgs_pkg::OP_READ;
    end
    if (state inside {S_INIT, S_CLEAR}) cmd.op = pgs_pkg::OP_CLEAR;
    if (state == S_UPD) cmd.op = pgs_pkg::OP_UPDATE;
    if (state == S_RES) begin
      cmd.op = pgs_pkg::OP_RESID;
      cmd.acc_clear = addr == '0 && tap == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      out_valid <= 1'b0;
      tap <= 3'd4;
      addr <= '0;
      col <= '0;
      row <= '0;
      sweeps <= '0;
      drain <= '0;
      out_data <= '0;
    end else begin
      if (out_set) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          tap <= 3'd4;
          if (in_acc) begin
            out_data <= '0;
            if (in_data.kind == pgs_pkg::KIND_READ) state <= S_READ;
            else if (in_data.kind == pgs_pkg::KIND_SOLVE) begin
              state <= S_CLEAR;
              addr <= '0;
            end
          end
        end
        S_READ: begin
          out_data.read_value <= read_data;
          state <= S_IDLE;
        end
        S_INIT, S_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == '1) begin
            if (state == S_INIT) state <= S_IDLE;
            else begin
              col <= '0;
              row <= '0;
              tap <= '0;
              sweeps <= '0;
              state <= S_UPD;
            end
          end
        end
        S_UPD, S_RES: begin
          if (tap != 3'd4) tap <= tap + 1'b1;
          else if (last_cell) begin
            addr <= '0;
            col <= '0;
            row <= '0;
            if (state == S_UPD) begin
              tap <= '0;
              sweeps <= sweeps + 1'b1;
              state <= S_RES;
            end else begin
              tap <= 3'd4;
              drain <= '0;
              state <= S_DRAIN;
            end
          end else begin
            tap <= '0;
            addr <= addr + 1'b1;
            if ({1'b0, col} + 1'b1 == width) begin
              col <= '0;
              row <= row + 1'b1;
            end else col <= col + 1'b1;
          end
        end
        S_DRAIN: begin
          // squaring pipeline settles into the accumulator
          drain <= drain + 1'b1;
          if (drain == 4'd4) state <= S_CHECK;
        end
        S_CHECK: begin
          if (finish) begin
            out_data.sweep_count <= sweeps;
            out_data.converged <= acc < tol;
            out_data.residual_squared <= acc;
            state <= S_IDLE;
          end else begin
            tap <= '0;
            state <= S_UPD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/poisson_gauss_seidel_solver_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// poisson_gauss_seidel_solver_unit
// Gauss-Seidel five-point Poisson solver, Q16.16.
//
// Input channel in_valid/in_stall carries load, solve and read transactions;
// output channel out_valid/out_stall returns one result per transaction.
// Load and ignored kinds: result in the cycle after accept, one per cycle
// while out_stall is low. Read: result registered from the memory read port
// in S_READ; no new transaction until back in S_IDLE. Solve: a clearing
// pass over all 4096 solution memory cells, then per sweep an update pass
// and a residual pass, five taps per cell through one read port, then a
// pipeline drain and a convergence check. Input is held off during a solve.
// Reset returns registers to 64x64 grid, zero tolerance, 1000 sweeps and
// runs a clearing pass over all 4096 solution memory cells, during which
// input is stalled; the rhs memory is not cleared. When out_stall is high
// the result holds and no new transaction is taken. Configured via APB.
// ---------------------------------------------------------------------------
module poisson_gauss_seidel_solver_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pgs_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pgs_pkg::out_item_t      out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);
  logic [6:0] grid_width, grid_height;
  logic [62:0] tolerance_squared;
  logic [15:0] max_sweeps;
  logic [pgs_pkg::COL_BITS:0] width;
  logic [pgs_pkg::ROW_BITS:0] height;
  logic [15:0] limit;
  pgs_pkg::dp_cmd_t cmd;
  logic [2:0] tap;
  logic signed [31:0] read_data;
  logic [62:0] acc;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= 7'd64;
      grid_height <= 7'd64;
      tolerance_squared <= '0;
      max_sweeps <= 16'd1000;
    end else if (psel && penable && pwrite && paddr[4:3] == '0) begin
      case (paddr[4:3])
        pgs_pkg::REG_WIDTH: grid_width <= pwdata[6:0];
        default: ;
      endcase
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        pgs_pkg::REG_HEIGHT: grid_height <= pwdata[6:0];
        pgs_pkg::REG_TOL:    tolerance_squared <= pwdata[62:0];
        pgs_pkg::REG_SWEEPS: max_sweeps <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      pgs_pkg::REG_WIDTH:  prdata = 64'(grid_width);
      pgs_pkg::REG_HEIGHT: prdata = 64'(grid_height);
      pgs_pkg::REG_TOL:    prdata = 64'(tolerance_squared);
      default:             prdata = 64'(max_sweeps);
    endcase
  end

  assign width  = grid_width == '0 ? 7'd1 : (grid_width > 7'd64 ? 7'd64 : grid_width);
  assign height = grid_height == '0 ? 7'd1 : (grid_height > 7'd64 ? 7'd64 : grid_height);
  assign limit  = max_sweeps == '0 ? 16'd1 : max_sweeps;

  pgs_controller u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .width, .height, .tol(tolerance_squared), .limit, .cmd, .tap, .read_data, .acc
  );

  pgs_datapath u_dp (
    .clk, .rst, .cmd, .tap, .width, .height, .read_data, .acc
  );

  assert property (@(posedge clk) disable iff (rst) out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst) out_valid && out_stall |=> $stable(out_data))
    else $error("result changed under stall");
  assert property (@(posedge clk) disable iff (rst) out_valid && out_stall |-> in_stall)
    else $error("input taken while result stalled");
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the Gauss-Seidel Poisson solver unit.
//
// Loads, solves, reads and ignored kinds are sent from a queue of pending
// transactions. A behavioral model in this file predicts every result
// when its transaction is accepted. Results are compared field by field,
// in order. The grid, tolerance and sweep limit registers are written over
// APB between phases, while the unit is idle. Both channels get random gaps.
// ---------------------------------------------------------------------------
module tb_top;
  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam longint unsigned SAT63 = 64'h7FFF_FFFF_FFFF_FFFF;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  pgs_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pgs_pkg::out_item_t out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;

  poisson_gauss_seidel_solver_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // model state and shadow registers
  logic signed [31:0] rhs_mem [pgs_pkg::CELLS];
  logic signed [31:0] sol_mem [pgs_pkg::CELLS];
  logic [6:0]         grid_w_reg = 7'd64;
  logic [6:0]         grid_h_reg = 7'd64;
  logic [62:0]        tol_reg = '0;
  logic [15:0]        sweeps_reg = 16'd1000;

  pgs_pkg::in_item_t  pending_items [$];
  pgs_pkg::out_item_t expected_results [$];
  int        fail_count = 0;
  bit        taken = 1'b0;
  bit        calm = 1'b0;
  bit        hold_req = 1'b0;
  int        hold_cnt = 0;
  int        send_gap = 0;
  int        stall_len = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int dim(logic [6:0] v, int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic longint nbr_sum(int idx, int c, int r, int w, int h);
    longint s;
    s = 0;
    if (c > 0) s += sol_mem[idx - 1];
    if (c < w - 1) s += sol_mem[idx + 1];
    if (r > 0) s += sol_mem[idx - w];
    if (r < h - 1) s += sol_mem[idx + w];
    return s;
  endfunction

  function automatic void run_solve(ref pgs_pkg::out_item_t res);
    int w, h, lim, sweeps, idx;
    longint s, e, q;
    longint unsigned mag, sq, acc;
    bit done;
    w = dim(grid_w_reg, pgs_pkg::MAX_WIDTH);
    h = dim(grid_h_reg, pgs_pkg::MAX_HEIGHT);
    lim = (sweeps_reg == 0) ? 1 : sweeps_reg;
    foreach (sol_mem[i]) sol_mem[i] = '0;
    sweeps = 0;
    acc = 0;
    done = 1'b0;
    while (!done) begin
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++) begin
          idx = r * w + c;
          q = (nbr_sum(idx, c, r, w, h) - rhs_mem[idx]) >>> 2;
          if (q > 64'sd2147483647) q = 64'sd2147483647;
          if (q < -64'sd2147483648) q = -64'sd2147483648;
          sol_mem[idx] = q[31:0];
        end
      sweeps++;
      acc = 0;
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++) begin
          idx = r * w + c;
          s = nbr_sum(idx, c, r, w, h);
          e = rhs_mem[idx] - (s - 4 * longint'(sol_mem[idx]));
          mag = (e < 0) ? -e : e;
          sq = (mag > pgs_pkg::SQ_LIMIT) ? SAT63 : mag * mag;
          acc = (acc > SAT63 - sq) ? SAT63 : acc + sq;
        end
      if (acc < {1'b0, tol_reg}) begin
        res.converged = 1'b1;
        done = 1'b1;
      end else if (sweeps >= lim) begin
        done = 1'b1;
      end
    end
    res.sweep_count = sweeps[15:0];
    res.residual_squared = acc[62:0];
  endfunction

  function automatic pgs_pkg::out_item_t compute_result(pgs_pkg::in_item_t it);
    pgs_pkg::out_item_t res;
    res = '0;
    case (it.kind)
      pgs_pkg::KIND_LOAD: rhs_mem[it.cell_index] = it.cell_value;
      pgs_pkg::KIND_SOLVE: run_solve(res);
      pgs_pkg::KIND_READ: res.read_value = sol_mem[it.cell_index];
      default: ;
    endcase
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      expected_results.push_back(compute_result(in_data));
      taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || taken) begin
      taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        send_gap = calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 300;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (stall_len > 0) begin
      stall_len--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_len = calm ? 0 : pick_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    pgs_pkg::out_item_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction");
        fail_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data.read_value !== exp_res.read_value) begin
          $error("read_value exp %0d got %0d", exp_res.read_value, out_data.read_value);
          fail_count++;
        end
        if (out_data.sweep_count !== exp_res.sweep_count) begin
          $error("sweep_count exp %0d got %0d", exp_res.sweep_count, out_data.sweep_count);
          fail_count++;
        end
        if (out_data.converged !== exp_res.converged) begin
          $error("converged exp %0d got %0d", exp_res.converged, out_data.converged);
          fail_count++;
        end
        if (out_data.residual_squared !== exp_res.residual_squared) begin
          $error("residual_squared exp %0h got %0h",
                 exp_res.residual_squared, out_data.residual_squared);
          fail_count++;
        end
      end
    end
  end

  task automatic push_item(logic [1:0] kind, int idx, logic [31:0] val);
    pgs_pkg::in_item_t it;
    it.kind = kind;
    it.cell_index = idx[11:0];
    it.cell_value = val;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 32'h7FFF_FFFF;
    if (r == 1) return 32'h8000_0000;
    if (r < 4) return $urandom;
    return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] reg_idx, logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_idx)
      pgs_pkg::REG_WIDTH: grid_w_reg = val[6:0];
      pgs_pkg::REG_HEIGHT: grid_h_reg = val[6:0];
      pgs_pkg::REG_TOL: tol_reg = val[62:0];
      default: sweeps_reg = val[15:0];
    endcase
  endtask

  task automatic set_config(logic [6:0] w, logic [6:0] h, logic [62:0] tol,
                            logic [15:0] sweeps);
    wait_idle();
    apb_write(pgs_pkg::REG_WIDTH, {57'd0, w});
    apb_write(pgs_pkg::REG_HEIGHT, {57'd0, h});
    apb_write(pgs_pkg::REG_TOL, {1'b0, tol});
    apb_write(pgs_pkg::REG_SWEEPS, {48'd0, sweeps});
  endtask

  task automatic load_grid(bit moderate);
    int n;
    n = dim(grid_w_reg, pgs_pkg::MAX_WIDTH) * dim(grid_h_reg, pgs_pkg::MAX_HEIGHT);
    for (int i = 0; i < n; i++)
      push_item(pgs_pkg::KIND_LOAD, i,
                moderate ? $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000 : pick_value());
  endtask

  task automatic random_phase(bit with_hold);
    int n, r, solves;
    logic [62:0] tol;
    r = $urandom_range(0, 3);
    tol = (r == 0) ? 63'd0 : (r == 1) ? pgs_pkg::CAP63 :
          (r == 2) ? 63'({$urandom, $urandom}) : 63'({$urandom_range(0, 255), 32'd0});
    set_config(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)), tol,
               16'($urandom_range(1, 12)));
    calm = ($urandom_range(0, 3) == 0);
    n = dim(grid_w_reg, pgs_pkg::MAX_WIDTH) * dim(grid_h_reg, pgs_pkg::MAX_HEIGHT);
    load_grid(1'b0);
    if (with_hold) hold_req = 1'b1;
    solves = 0;
    for (int i = 0; i < 60; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        push_item(pgs_pkg::KIND_LOAD,
                  (r < 30) ? $urandom_range(0, n - 1) : $urandom_range(0, 4095),
                  pick_value());
      else if (r < 85 || solves >= 3)
        push_item(pgs_pkg::KIND_READ,
                  (r < 75) ? $urandom_range(0, n - 1) : $urandom_range(0, 4095),
                  $urandom);
      else if (r < 92)
        push_item(KIND_NOP, $urandom_range(0, 4095), $urandom);
      else begin
        push_item(pgs_pkg::KIND_SOLVE, $urandom_range(0, 4095), $urandom);
        solves++;
      end
    end
    push_item(pgs_pkg::KIND_SOLVE, 0, 0);
    for (int i = 0; i < n; i++) push_item(pgs_pkg::KIND_READ, i, 0);
  endtask

  initial begin
    foreach (sol_mem[i]) sol_mem[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: loads, reads and an ignored kind, no solve
    push_item(pgs_pkg::KIND_LOAD, 4095, 32'h8000_0000);
    push_item(pgs_pkg::KIND_LOAD, 0, 32'h7FFF_FFFF);
    push_item(pgs_pkg::KIND_READ, 4095, 32'hFFFF_FFFF);
    push_item(pgs_pkg::KIND_READ, 0, 0);
    push_item(KIND_NOP, 4095, 32'hFFFF_FFFF);

    // zero width, height and sweep limit act as one
    set_config(7'd0, 7'd0, 63'd0, 16'd0);
    push_item(pgs_pkg::KIND_SOLVE, 0, 0);
    push_item(pgs_pkg::KIND_READ, 0, 0);
    push_item(pgs_pkg::KIND_READ, 4095, 0);
    push_item(pgs_pkg::KIND_LOAD, 0, 32'h0001_0000);
    push_item(pgs_pkg::KIND_SOLVE, 0, 0);
    push_item(pgs_pkg::KIND_READ, 0, 0);

    // oversized width clamps to the maximum, huge tolerance, extreme values
    set_config(7'd127, 7'd1, pgs_pkg::CAP63, 16'd3);
    load_grid(1'b0);
    push_item(pgs_pkg::KIND_SOLVE, 0, 0);
    push_item(pgs_pkg::KIND_READ, 0, 0);
    push_item(pgs_pkg::KIND_READ, 63, 0);

    // tall column, sweep limit at its top; moderate rhs converges at once
    set_config(7'd1, 7'd100, pgs_pkg::CAP63, 16'hFFFF);
    load_grid(1'b1);
    push_item(pgs_pkg::KIND_SOLVE, 0, 0);
    push_item(pgs_pkg::KIND_READ, 63, 0);
    push_item(pgs_pkg::KIND_READ, 64, 0);

    // max width, three rows, one sweep
    set_config(7'd64, 7'd3, 63'd1, 16'd1);
    load_grid(1'b1);
    push_item(pgs_pkg::KIND_SOLVE, 0, 0);
    push_item(pgs_pkg::KIND_READ, 191, 0);
    push_item(pgs_pkg::KIND_READ, 4095, 0);

    for (int p = 0; p < 5; p++) random_phase(p == 2);

    wait_idle();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("tb_top NOT OK");
    $finish;
  end
endmodule

FILE: sim.f
rtl/pgs_pkg.sv
rtl/pgs_datapath.sv
rtl/pgs_controller.sv
rtl/poisson_gauss_seidel_solver_unit.sv
bench/tb_top.sv
